@@ src/cma_pkg.sv @@
// Shared types, constants and helpers of the covariance matrix accumulator.
package cma_pkg;

  localparam int unsigned MaxDims           = 8;
  localparam int unsigned TriSize           = MaxDims * (MaxDims + 1) / 2;
  localparam int unsigned TriAw             = $clog2(TriSize);
  localparam int unsigned MaxSamplesDefault = 65536;
  localparam int unsigned CountW            = 17;
  localparam int unsigned SumW              = 32;
  localparam int unsigned ProdSumW          = 48;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ABS_A,
    ST_ABS_M,
    ST_ABS_W,
    ST_OUT_START,
    ST_OUT_SX,
    ST_OUT_SY,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_XY,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Position of entry (r, c), r <= c, in the packed upper triangle.
  function automatic logic [TriAw-1:0] tri_idx(input logic [2:0] r, input logic [2:0] c);
    logic [5:0] rr;
    logic [5:0] cc;
    logic [5:0] idx;
    rr  = {3'b000, r};
    cc  = {3'b000, c};
    idx = (rr << 3) - ((rr * (rr - 6'd1)) >> 1) + cc - rr;
    return TriAw'(idx);
  endfunction

endpackage

@@ src/cma_ram.sv @@
// Generic single write port RAM with a registered read port.
module cma_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/covariance_matrix_accumulator.sv @@
// Top level of the covariance matrix accumulator: sequencer and shared datapath.
//
// Channel  | Handshake               | Word
// ---------+-------------------------+----------------------------------------------
// cfg      | cfg_we_i                | cfg_wdata_i (dims_in_use)
// in       | in_valid_i / in_ready_o | sample_value_i, end_of_set_i
// out      | out_valid_o/out_ready_i | row/col index, covariance, last, flags
//
// A word that completes a sample while the sample count is below MaxSamples passes
// through the shared multiplier and the read-modify-write of the product sum RAM.
// At end of a non-empty set each matrix entry runs the 64-step restoring divider,
// plus the wait for the output to be taken.
// After reset and after each matrix a pass over all 36 entries clears the product sum RAM.
// The block takes no input word while it works; a stalled output holds.
module covariance_matrix_accumulator
  import cma_pkg::*;
#(
  parameter int unsigned MaxSamples = MaxSamplesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_value_i,
  input  logic               end_of_set_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         row_index_o,
  output logic [2:0]         col_index_o,
  output logic signed [31:0] covariance_o,
  output logic               last_entry_o,
  output logic               no_samples_o,
  output logic               count_overflow_o
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxSamples);

  state_e state_q, state_d;

  logic [3:0]            dims_q;
  logic [3:0]            dims_act;
  logic [2:0]            dlast;
  logic [15:0]           buf_q [MaxDims];
  logic [SumW-1:0]       csum_q [MaxDims];
  logic [2:0]            pos_q;
  logic [CountW-1:0]     count_q;
  logic                  ovf_q;
  logic                  eos_q;
  logic [2:0]            i_q, j_q;
  logic [15:0]           a_q;
  logic signed [31:0]    p_q;
  logic [TriAw-1:0]      clr_q;
  logic signed [31:0]    sx_q, sy_q;
  logic [ProdSumW-1:0]   sxy_q;
  logic [63:0]           acc_q;
  logic [32:0]           nsq_q;
  logic [63:0]           dvd_q;
  logic [32:0]           rem_q;
  logic [31:0]           quo_q;
  logic                  neg_q;
  logic [5:0]            cnt_q;
  logic signed [31:0]    cov_q;

  logic                  in_fire, complete, full;
  logic                  ram_we;
  logic [TriAw-1:0]      ram_addr;
  logic [ProdSumW-1:0]   ram_wdata, ram_rdata;
  logic [2:0]            rmin, rmax;
  logic [40:0]           lo_prod;
  logic signed [41:0]    hi_prod;
  logic signed [63:0]    xy_prod;
  logic [33:0]           nsq_full;
  logic [33:0]           trial;
  logic                  qbit;
  logic [31:0]           quo_next;
  logic                  last_rc;

  assign dims_act = (dims_q == 4'd0) ? 4'd1 :
                    (dims_q > 4'(MaxDims)) ? 4'(MaxDims) : dims_q;
  assign dlast    = 3'(dims_act - 4'd1);
  assign in_fire  = in_valid_i && in_ready_o;
  assign complete = ({1'b0, pos_q} + 4'd1) >= dims_act;
  assign full     = count_q >= MaxCount;
  assign rmin     = (i_q <= j_q) ? i_q : j_q;
  assign rmax     = (i_q <= j_q) ? j_q : i_q;
  assign last_rc  = (i_q == dlast) && (j_q == dlast);

  // Product terms: n * Sxy is split into a low and a high partial product.
  assign lo_prod  = count_q * sxy_q[23:0];
  assign hi_prod  = $signed({1'b0, count_q}) * $signed(sxy_q[47:24]);
  assign xy_prod  = sx_q * sy_q;
  assign nsq_full = count_q * count_q;
  assign trial    = {rem_q, dvd_q[63]};
  assign qbit     = trial >= {1'b0, nsq_q};
  assign quo_next = {quo_q[30:0], qbit};

  cma_ram #(
    .Width (ProdSumW),
    .Depth (TriSize)
  ) u_psum_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == TriAw'(TriSize - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (complete && !full) state_d = ST_ABS_A;
          else if (end_of_set_i) state_d = ST_OUT_START;
        end
      end
      ST_ABS_A: state_d = ST_ABS_M;
      ST_ABS_M: state_d = ST_ABS_W;
      ST_ABS_W: begin
        if (j_q != dlast) state_d = ST_ABS_M;
        else if (i_q != dlast) state_d = ST_ABS_A;
        else if (eos_q) state_d = ST_OUT_START;
        else state_d = ST_IDLE;
      end
      ST_OUT_START: state_d = (count_q == '0) ? ST_EMIT : ST_OUT_SX;
      ST_OUT_SX:    state_d = ST_OUT_SY;
      ST_OUT_SY:    state_d = ST_MUL_LO;
      ST_MUL_LO:    state_d = ST_MUL_HI;
      ST_MUL_HI:    state_d = ST_MUL_XY;
      ST_MUL_XY:    state_d = ST_DIV_INIT;
      ST_DIV_INIT:  state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == 6'd63) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (last_rc) state_d = ST_CLEAR;
          else if (count_q == '0) state_d = ST_EMIT;
          else state_d = ST_OUT_SX;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs and RAM control.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = tri_idx(rmin, rmax);
    ram_wdata   = ram_rdata + {{(ProdSumW - 32){p_q[31]}}, p_q};
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE:  in_ready_o  = 1'b1;
      ST_ABS_W: ram_we      = 1'b1;
      ST_EMIT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign row_index_o      = i_q;
  assign col_index_o      = j_q;
  assign covariance_o     = cov_q;
  assign last_entry_o     = last_rc;
  assign no_samples_o     = (count_q == '0);
  assign count_overflow_o = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      dims_q  <= 4'(MaxDims);
      pos_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      eos_q   <= 1'b0;
      clr_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
      for (int k = 0; k < MaxDims; k++) csum_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) dims_q <= cfg_wdata_i;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + TriAw'(1);
          for (int k = 0; k < MaxDims; k++) csum_q[k] <= '0;
          count_q <= '0;
          ovf_q   <= 1'b0;
          pos_q   <= '0;
        end
        ST_IDLE: begin
          if (in_fire) begin
            buf_q[pos_q] <= sample_value_i;
            eos_q        <= end_of_set_i;
            i_q          <= '0;
            j_q          <= '0;
            if (complete) begin
              pos_q <= '0;
              if (full) ovf_q <= 1'b1;
            end else begin
              pos_q <= pos_q + 3'd1;
            end
          end
        end
        ST_ABS_A: begin
          a_q       <= buf_q[i_q];
          csum_q[i_q] <= csum_q[i_q] + {{16{buf_q[i_q][15]}}, buf_q[i_q]};
          j_q       <= i_q;
        end
        ST_ABS_M: p_q <= $signed(a_q) * $signed(buf_q[j_q]);
        ST_ABS_W: begin
          if (j_q != dlast) begin
            j_q <= j_q + 3'd1;
          end else if (i_q != dlast) begin
            i_q <= i_q + 3'd1;
          end else begin
            count_q <= count_q + CountW'(1);
            i_q     <= '0;
            j_q     <= '0;
          end
        end
        ST_OUT_START: begin
          nsq_q <= nsq_full[32:0];
          cov_q <= '0;
          clr_q <= '0;
        end
        ST_OUT_SX:  sx_q <= csum_q[i_q];
        ST_OUT_SY: begin
          sy_q  <= csum_q[j_q];
          sxy_q <= ram_rdata;
        end
        ST_MUL_LO:  acc_q <= {23'b0, lo_prod};
        ST_MUL_HI:  acc_q <= acc_q + {hi_prod[39:0], 24'b0};
        ST_MUL_XY:  acc_q <= acc_q - xy_prod;
        ST_DIV_INIT: begin
          neg_q <= acc_q[63];
          dvd_q <= acc_q[63] ? (64'd0 - acc_q) : acc_q;
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= '0;
        end
        ST_DIV: begin
          rem_q <= qbit ? 33'(trial - {1'b0, nsq_q}) : trial[32:0];
          dvd_q <= {dvd_q[62:0], 1'b0};
          quo_q <= quo_next;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) cov_q <= neg_q ? (32'd0 - quo_next) : quo_next;
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            if (last_rc) begin
              i_q <= '0;
              j_q <= '0;
            end else if (j_q == dlast) begin
              i_q <= i_q + 3'd1;
              j_q <= '0;
            end else begin
              j_q <= j_q + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the covariance matrix accumulator.
module tb;
  import cma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] cov;
    logic               last;
    logic               empty;
    logic               ovf;
  } entry_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [3:0]         cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] sample_value_i;
  logic               end_of_set_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         row_index_o;
  logic [2:0]         col_index_o;
  logic signed [31:0] covariance_o;
  logic               last_entry_o;
  logic               no_samples_o;
  logic               count_overflow_o;

  covariance_matrix_accumulator uut (.*);

  // Shadow state of the block.
  logic [3:0]         dims_reg;
  logic [31:0]        sums [MaxDims];
  logic [47:0]        prods [MaxDims][MaxDims];
  logic signed [15:0] held [MaxDims];
  int unsigned        comp_pos;
  int unsigned        n_samples;
  bit                 ovf_seen;

  entry_t expected_entries[$];
  int     errors;
  int     entries_seen;
  int     sets_sent;
  int     words_sent;
  bit     stall_on;
  longint cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 64'd3000000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic void clear_sums();
    for (int i = 0; i < MaxDims; i++) begin
      sums[i] = '0;
      for (int j = 0; j < MaxDims; j++) prods[i][j] = '0;
    end
    comp_pos  = 0;
    n_samples = 0;
    ovf_seen  = 1'b0;
  endfunction

  function automatic int unsigned eff_dims();
    if (dims_reg == 0) return 1;
    if (dims_reg > MaxDims) return MaxDims;
    return dims_reg;
  endfunction

  function automatic logic [31:0] cov_entry(int r, int c);
    longint sx, sy, sxy, n, diff;
    int a, b;
    a = (r < c) ? r : c;
    b = (r < c) ? c : r;
    if (n_samples == 0) return '0;
    n    = n_samples;
    sx   = longint'($signed(sums[r]));
    sy   = longint'($signed(sums[c]));
    sxy  = longint'($signed(prods[a][b]));
    diff = n * sxy - sx * sy;
    return 32'(diff / (n * n));
  endfunction

  // Predicts the effect of one accepted word.
  function automatic void predict_word(logic signed [15:0] v, logic eos);
    int unsigned d;
    entry_t e;
    d = eff_dims();
    held[comp_pos] = v;
    if (comp_pos + 1 >= d) begin
      if (n_samples >= 65536) ovf_seen = 1'b1;
      else begin
        for (int i = 0; i < d; i++) begin
          sums[i] = sums[i] + 32'(longint'(held[i]));
          for (int j = i; j < d; j++)
            prods[i][j] = prods[i][j] + 48'(longint'(held[i]) * longint'(held[j]));
        end
        n_samples++;
      end
      comp_pos = 0;
    end else comp_pos = (comp_pos + 1) % 8;
    if (eos) begin
      for (int r = 0; r < d; r++)
        for (int c = 0; c < d; c++) begin
          e.row   = 3'(r);
          e.col   = 3'(c);
          e.cov   = cov_entry(r, c);
          e.last  = (r == d - 1) && (c == d - 1);
          e.empty = (n_samples == 0);
          e.ovf   = ovf_seen;
          expected_entries.push_back(e);
        end
      clear_sums();
      sets_sent++;
    end
  endfunction

  // Checks each result word and drives the output stall.
  initial begin
    entry_t exp_e;
    int     gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 8);
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        entries_seen++;
        if (expected_entries.size() == 0) begin
          $display("%0t unexpected word: row %0d col %0d cov %0d", $time,
                   row_index_o, col_index_o, covariance_o);
          errors++;
        end else begin
          exp_e = expected_entries.pop_front();
          if (exp_e.row !== row_index_o || exp_e.col !== col_index_o ||
              exp_e.cov !== covariance_o || exp_e.last !== last_entry_o ||
              exp_e.empty !== no_samples_o || exp_e.ovf !== count_overflow_o) begin
            $display("%0t mismatch: expected r%0d c%0d cov %0d last %0b empty %0b ovf %0b",
                     $time, exp_e.row, exp_e.col, exp_e.cov, exp_e.last, exp_e.empty,
                     exp_e.ovf);
            $display("%0t           actual   r%0d c%0d cov %0d last %0b empty %0b ovf %0b",
                     $time, row_index_o, col_index_o, covariance_o, last_entry_o,
                     no_samples_o, count_overflow_o);
            errors++;
          end
        end
      end
    end
  end

  // Entered and left at a falling edge; valid stays high so that words can follow
  // back to back, and whoever stops sending lowers it.
  task automatic send_word(logic signed [15:0] v, logic eos);
    if (stall_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    sample_value_i <= v;
    end_of_set_i   <= eos;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(v, eos);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_dims(logic [3:0] d);
    drain();
    cfg_wdata_i <= d;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    dims_reg = d;
  endtask

  task automatic send_set(int unsigned n_words, int mode);
    logic signed [15:0] v;
    for (int i = 0; i < n_words; i++) begin
      case (mode)
        0: v = 16'($urandom());
        1: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        default: v = 16'($signed($urandom_range(0, 200)) - 100);
      endcase
      send_word(v, i == n_words - 1);
    end
  endtask

  task automatic test_directed();
    write_dims(4'd8);
    send_word(16'sh7fff, 1'b1);            // partial sample only: empty set
    send_set(16, 1);                       // extreme values, full width
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b1);            // partial sample dropped
    write_dims(4'd1);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b1);
    write_dims(4'd0);                      // acts as one dimension
    send_set(3, 1);
    write_dims(4'd15);                     // clamped to the maximum
    send_set(8, 0);
  endtask

  task automatic test_dims_change_mid_set();
    write_dims(4'd4);
    send_word(16'sd100, 1'b0);
    send_word(16'sd200, 1'b0);
    send_word(16'sd300, 1'b0);
    dims_reg = 4'd2;
    in_valid_i  <= 1'b0;
    cfg_wdata_i <= 4'd2;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    send_word(-16'sd50, 1'b0);
    send_word(16'sd7, 1'b1);
  endtask

  task automatic test_random();
    int unsigned d, n;
    for (int s = 0; s < 12; s++) begin
      if (s % 3 == 0) write_dims(4'($urandom_range(1, 8)));
      d = eff_dims();
      n = d * $urandom_range(1, 4) + (($urandom_range(0, 4) == 0) ? $urandom_range(0, d) : 0);
      send_set(n, $urandom_range(0, 2));
    end
  endtask

  initial begin
    errors = 0; entries_seen = 0; sets_sent = 0; words_sent = 0;
    stall_on = 1'b1;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; sample_value_i = '0; end_of_set_i = 1'b0;
    dims_reg = 4'd8;
    for (int i = 0; i < MaxDims; i++) held[i] = '0;
    clear_sums();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_dims_change_mid_set();
    test_random();
    stall_on = 1'b0;
    test_random();
    drain();
    $display("Covered %0d words in %0d sets, %0d matrix entries checked.",
             words_sent, sets_sent, entries_seen);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
